>>> design/mac_learning_forward_table_defines.svh
// Assertion macros used by the checker file of the MAC learning table.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef MAC_LEARNING_FORWARD_TABLE_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define MLFT_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define MLFT_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/mlft_pkg.sv
// Shared sizes, types and request/result structs of the MAC learning table.
// Used by every module of the block but mlft_ram; depends on nothing.
package mlft_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int NUM_PORTS     = 16;

	localparam int MAC_W   = 48;
	localparam int PORT_W  = 4;
	localparam int ENTRY_W = MAC_W + PORT_W;
	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);

	localparam int IN_TDATA_W = ((2 * MAC_W + PORT_W + 7) / 8) * 8;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic [PORT_W-1:0] in_port;
		logic              learn_en;
	} req_t;

	// The last field, dst_known, sits in the lowest bit.
	typedef struct packed {
		logic              learn_dropped;
		logic              port_moved;
		logic              learned_new;
		logic [PORT_W-1:0] out_port;
		logic              dst_known;
	} res_t;

	localparam int OUT_TDATA_W = $bits(res_t);

endpackage

>>> design/mac_learning_forward_table.sv
// Top level of the Ethernet MAC learning and forwarding table.
// Depends on mlft_pkg, mlft_front, mlft_queue and mlft_back.
//
// Usage: each slave-side beat carries one frame header (source MAC, destination
// MAC, ingress port). Each header yields exactly one master-side beat telling
// whether the destination is known and on which port, and what learning did
// with the source: appended, moved to a new port, or dropped because the table
// is full. The destination is looked up before the source is learned, so a
// destination equal to a brand new source floods. Headers from a port number at
// or above NUM_PORTS are looked up but never learned.
// Timing: the front end registers a header and hands it to a two-entry queue,
// so headers keep being taken while the engine works. The engine's work per
// header is set by the single read port of the table memory, which the engine
// walks one entry per cycle, comparing both addresses against each learned
// entry; while the table is empty no walk is run.
// Reset empties the table at once through the fill count; no clearing pass is
// run. A stalled result is held in the output register; the engine then waits
// before learning, and the queue fills until the slave side deasserts tready.
module mac_learning_forward_table
	import mlft_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// src_mac [47:0], dst_mac [95:48], in_port [99:96], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// dst_known [0], out_port [4:1], learned_new [5], port_moved [6],
	// learn_dropped [7]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic front_valid;
	logic front_ready;
	req_t front_req;
	logic queue_valid;
	logic queue_ready;
	req_t queue_req;

	// Unpacks each header and flags whether its ingress port may be learned.
	mlft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.req_valid    (front_valid),
		.req_ready    (front_ready),
		.req_data     (front_req)
	);

	// Buffers pending headers so either side can stall without the other.
	mlft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_data (front_req),
		.pop_valid (queue_valid),
		.pop_ready (queue_ready),
		.pop_data  (queue_req)
	);

	// Scans the table, learns the source and presents the result beat.
	mlft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (queue_valid),
		.req_ready    (queue_ready),
		.req_data     (queue_req),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

>>> design/mlft_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mlft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/mlft_front.sv
// Front end: takes header beats, unpacks and classifies them into requests.
// Depends on mlft_pkg.
module mlft_front
	import mlft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic                  req_valid,
	input  logic                  req_ready,
	output req_t                  req_data
);

	req_t req_s1;
	logic valid_s1;
	req_t req_dec;

	// Only a real port may teach the table; other headers are looked up only.
	always_comb begin
		req_dec.src_mac  = s_axis_tdata[MAC_W-1:0];
		req_dec.dst_mac  = s_axis_tdata[2*MAC_W-1:MAC_W];
		req_dec.in_port  = s_axis_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
		req_dec.learn_en = int'(req_dec.in_port) < NUM_PORTS;
	end

	assign s_axis_tready = !valid_s1 || req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
			req_s1   <= req_dec;
		end else if (req_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign req_valid = valid_s1;
	assign req_data  = req_s1;

endmodule

>>> design/mlft_queue.sv
// Short request queue that decouples the front end from the table engine.
// Depends on mlft_pkg.
module mlft_queue
	import mlft_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  req_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output req_t pop_data
);

	localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W = $clog2(Q_DEPTH + 1);

	req_t              slot_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q != QCNT_W'(Q_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> design/mlft_back.sv
// Back end: walks the table memory for both addresses, then learns the source.
// Depends on mlft_pkg and mlft_ram; drives the result stream.
module mlft_back
	import mlft_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_t                   req_data,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic               dst_hit_q;
	logic [PORT_W-1:0]  dst_port_q;
	logic               src_hit_q;
	logic [IDX_W-1:0]   src_idx_q;
	logic [PORT_W-1:0]  src_port_q;
	logic               out_valid_q;
	res_t               out_res_q;

	logic [ENTRY_W-1:0] rd_data;
	logic [MAC_W-1:0]   rd_mac;
	logic [PORT_W-1:0]  rd_port;
	logic               dst_match;
	logic               src_match;
	logic               last_issue;
	logic               out_free;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               count_inc;
	res_t               fin_res;

	mlft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign rd_mac     = rd_data[ENTRY_W-1:PORT_W];
	assign rd_port    = rd_data[PORT_W-1:0];
	// Stored addresses are unique, so at most one entry matches each key.
	assign dst_match  = pend_q && (rd_mac == req_q.dst_mac);
	assign src_match  = pend_q && (rd_mac == req_q.src_mac);
	assign last_issue = CNT_W'(idx_q) == (count_q - CNT_W'(1));
	assign out_free   = !out_valid_q || m_axis_tready;
	assign req_ready  = state_q == ST_IDLE;

	always_comb begin
		fin_res           = '0;
		fin_res.dst_known = dst_hit_q;
		fin_res.out_port  = dst_port_q;
		ram_waddr         = src_idx_q;
		ram_wdata         = {req_q.src_mac, req_q.in_port};
		count_inc         = 1'b0;
		priority if (!req_q.learn_en) begin
			fin_res.learned_new = 1'b0;
		end else if (src_hit_q) begin
			fin_res.port_moved = src_port_q != req_q.in_port;
		end else if (count_q < CNT_W'(TABLE_ENTRIES)) begin
			fin_res.learned_new = 1'b1;
			ram_waddr           = count_q[IDX_W-1:0];
			count_inc           = 1'b1;
		end else begin
			fin_res.learn_dropped = 1'b1;
		end
		ram_we = (state_q == ST_FINISH) && out_free
			&& (fin_res.learned_new || fin_res.port_moved);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (dst_match) begin
				dst_hit_q  <= 1'b1;
				dst_port_q <= rd_port;
			end
			if (src_match) begin
				src_hit_q  <= 1'b1;
				src_idx_q  <= pend_idx_q;
				src_port_q <= rd_port;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q      <= req_data;
						idx_q      <= '0;
						dst_hit_q  <= 1'b0;
						dst_port_q <= '0;
						src_hit_q  <= 1'b0;
						state_q    <= (count_q == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_q     <= 1'b1;
					pend_idx_q <= idx_q;
					idx_q      <= idx_q + IDX_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_res_q   <= fin_res;
						count_q     <= count_q + CNT_W'(count_inc);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q;

endmodule

>>> design/mlft_checker.sv
// Port-level checks of the MAC learning table and the bind that attaches them.
// Depends on mlft_pkg and mac_learning_forward_table_defines.svh.
`include "mac_learning_forward_table_defines.svh"

module mlft_checker
	import mlft_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A result beat that is not taken stays put.
	`MLFT_ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// A flooded frame reports port zero.
	`MLFT_ASSERT_CLK(a_flood_port, m_axis_tvalid |-> m_axis_tdata[0] || (m_axis_tdata[4:1] == '0), "out_port set on a flood")

	// Learning has at most one outcome per header.
	`MLFT_ASSERT_CLK(a_learn_onehot, m_axis_tvalid |-> $countones(m_axis_tdata[7:5]) <= 1, "more than one learn flag set")

	// No result is offered while reset is held.
	`MLFT_ASSERT_RST(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "result beat during reset")

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
